// ===== rtl/oled_text_glyph_writer_macros.svh =====
// assertion macros for the oled text glyph writer checker
`ifndef OLED_TEXT_GLYPH_WRITER_MACROS_SVH
`define OLED_TEXT_GLYPH_WRITER_MACROS_SVH

// checked only while out of reset
`define OTGW_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define OTGW_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/otgw_pkg.sv =====
// shared types, beat codes, glyph mapping and font rom for the glyph writer
package otgw_pkg;

  localparam int GLYPH_COUNT = 67;
  localparam int QUEUE_DEPTH = 2;

  typedef logic [6:0] glyph_idx_t;
  typedef logic [3:0] beat_t;

  localparam beat_t BEAT_PAGE   = 4'd0;
  localparam beat_t BEAT_COL_HI = 4'd1;
  localparam beat_t BEAT_COL_LO = 4'd2;
  localparam beat_t BEAT_DATA0  = 4'd3;
  localparam beat_t BEAT_LAST   = 4'd8;

  localparam logic [7:0] CMD_PAGE   = 8'hB0;
  localparam logic [7:0] CMD_COL_HI = 8'h10;

  localparam glyph_idx_t GLYPH_SPACE   = 7'd0;
  localparam glyph_idx_t GLYPH_BANG    = 7'd1;
  localparam glyph_idx_t GLYPH_DIGIT0  = 7'd2;
  localparam glyph_idx_t GLYPH_UPPER_A = 7'd12;
  localparam glyph_idx_t GLYPH_PERIOD  = 7'd38;
  localparam glyph_idx_t GLYPH_MINUS   = 7'd39;
  localparam glyph_idx_t GLYPH_LOWER_A = 7'd40;
  localparam glyph_idx_t GLYPH_PERCENT = 7'd66;

  typedef struct packed {
    logic [2:0] page;
    logic [6:0] column;
    glyph_idx_t glyph;
  } glyph_job_t;

  localparam logic [47:0] FONT_ROM [GLYPH_COUNT] = '{
    48'h000000000000, 48'h0000002f0000, 48'h003E5149453E, 48'h0000427F4000,
    48'h004261514946, 48'h002141454B31, 48'h001814127F10, 48'h002745454539,
    48'h003C4A494930, 48'h000171090503, 48'h003649494936, 48'h00064949291E,
    48'h007C1211127C, 48'h007F49494936, 48'h003E41414122, 48'h007F4141221C,
    48'h007F49494941, 48'h007F09090901, 48'h003E4149497A, 48'h007F0808087F,
    48'h0000417F4100, 48'h002040413F01, 48'h007F08142241, 48'h007F40404040,
    48'h007F020C027F, 48'h007F0408107F, 48'h003E4141413E, 48'h007F09090906,
    48'h003E4151215E, 48'h007F09192946, 48'h004649494931, 48'h0001017F0101,
    48'h003F4040403F, 48'h001F2040201F, 48'h003F4038403F, 48'h006314081463,
    48'h000708700807, 48'h006151494543, 48'h000060600000, 48'h000808080808,
    48'h002054545478, 48'h007F48444438, 48'h003844444420, 48'h00384444487F,
    48'h003854545418, 48'h00087E090102, 48'h0018A4A4A47C, 48'h007F08040478,
    48'h0000447D4000, 48'h004080847D00, 48'h007F10284400, 48'h0000417F4000,
    48'h007C04180478, 48'h007C08040478, 48'h003844444438, 48'h00FC24242418,
    48'h0018242418FC, 48'h007C08040408, 48'h004854545420, 48'h00043F444020,
    48'h003C4040207C, 48'h001C2040201C, 48'h003C4030403C, 48'h004428102844,
    48'h001CA0A0A07C, 48'h004464544C44, 48'h006264081323
  };

  function automatic glyph_idx_t glyph_index(input logic [7:0] ch);
    glyph_idx_t idx;
    idx = GLYPH_SPACE;
    if (ch == 8'h21) idx = GLYPH_BANG;
    else if (ch >= 8'h30 && ch <= 8'h39) idx = GLYPH_DIGIT0 + 7'(ch - 8'h30);
    else if (ch >= 8'h41 && ch <= 8'h5A) idx = GLYPH_UPPER_A + 7'(ch - 8'h41);
    else if (ch == 8'h2E) idx = GLYPH_PERIOD;
    else if (ch == 8'h2D) idx = GLYPH_MINUS;
    else if (ch >= 8'h61 && ch <= 8'h7A) idx = GLYPH_LOWER_A + 7'(ch - 8'h61);
    else if (ch == 8'h25) idx = GLYPH_PERCENT;
    return idx;
  endfunction

  function automatic logic [7:0] font_byte(input glyph_idx_t idx, input logic [2:0] c);
    logic [47:0] row;
    logic [7:0]  b;
    row = (int'(idx) < GLYPH_COUNT) ? FONT_ROM[idx] : 48'h0;
    case (c)
      3'd0: b = row[47:40];
      3'd1: b = row[39:32];
      3'd2: b = row[31:24];
      3'd3: b = row[23:16];
      3'd4: b = row[15:8];
      3'd5: b = row[7:0];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ===== rtl/otgw_front.sv =====
// front end: accepts beats, keeps the cursor and queues glyph jobs
module otgw_front #(
  parameter int PAGES   = 8,
  parameter int COLUMNS = 128
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                kind,
  input  logic [6:0]          column,
  input  logic [2:0]          page,
  input  logic [7:0]          char_code,
  input  logic                queue_full,
  output logic                push,
  output otgw_pkg::glyph_job_t push_job
);
  import otgw_pkg::*;

  localparam logic [7:0] WRAP_LIMIT = 8'(COLUMNS - 8);

  logic [6:0] cursor_column, cursor_column_next;
  logic [2:0] cursor_page, cursor_page_next;
  logic       accept;
  logic [7:0] col_sum;

  function automatic logic [2:0] page_mod(input logic [2:0] p_in);
    logic [2:0] p;
    p = p_in;
    for (int i = 0; i < 3; i++) begin
      if (int'(p) >= PAGES) p = p - 3'(PAGES);
    end
    return p;
  endfunction

  assign in_stall = queue_full;
  assign accept   = in_valid && !in_stall;
  assign push     = accept && kind;
  assign col_sum  = {1'b0, cursor_column} + 8'd6;

  always_comb begin
    push_job.page   = cursor_page;
    push_job.column = cursor_column;
    push_job.glyph  = glyph_index(char_code);
  end

  always_comb begin
    cursor_column_next = cursor_column;
    cursor_page_next   = cursor_page;
    if (accept && !kind) begin
      cursor_column_next = column;
      cursor_page_next   = page_mod(page);
    end else if (push) begin
      if (col_sum > WRAP_LIMIT) begin
        cursor_column_next = 7'd0;
        cursor_page_next   = (int'(cursor_page) == PAGES - 1) ? 3'd0 : cursor_page + 3'd1;
      end else begin
        cursor_column_next = col_sum[6:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_column <= 7'd0;
      cursor_page   <= 3'd0;
    end else begin
      cursor_column <= cursor_column_next;
      cursor_page   <= cursor_page_next;
    end
  end

endmodule

// ===== rtl/otgw_queue.sv =====
// short job queue between front and back
module otgw_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  otgw_pkg::glyph_job_t push_job,
  output logic                 full,
  input  logic                 pop,
  output logic                 job_valid,
  output otgw_pkg::glyph_job_t pop_job
);
  import otgw_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  glyph_job_t       slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (int'(p) == QUEUE_DEPTH - 1) ? '0 : p + 1'b1;
  endfunction

  assign full      = (int'(count) == QUEUE_DEPTH);
  assign job_valid = (count != '0);
  assign pop_job   = slots[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && job_valid;

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= ptr_inc(wr_ptr);
      if (do_pop) rd_ptr <= ptr_inc(rd_ptr);
      if (do_push && !do_pop) count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

endmodule

// ===== rtl/otgw_back.sv =====
// back end: walks each glyph job through its nine output beats
module otgw_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 job_valid,
  input  otgw_pkg::glyph_job_t job,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           out_byte,
  output logic                 is_data,
  output logic                 last
);
  import otgw_pkg::*;

  glyph_job_t cur;
  logic       busy;
  beat_t      beat;
  logic [2:0] data_col;
  logic       advance, end_of_job;
  logic [7:0] byte_now;

  assign advance    = busy && (!out_valid || !out_stall);
  assign end_of_job = advance && (beat == BEAT_LAST);
  assign pop        = job_valid && (!busy || end_of_job);
  assign data_col   = 3'(beat - BEAT_DATA0);

  always_comb begin
    case (beat)
      BEAT_PAGE:   byte_now = CMD_PAGE + {5'd0, cur.page};
      BEAT_COL_HI: byte_now = CMD_COL_HI | {5'd0, cur.column[6:4]};
      BEAT_COL_LO: byte_now = {4'd0, cur.column[3:0]};
      default:     byte_now = font_byte(cur.glyph, data_col);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      beat      <= BEAT_PAGE;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        busy <= 1'b1;
        beat <= BEAT_PAGE;
      end else if (end_of_job) begin
        busy <= 1'b0;
      end else if (advance) begin
        beat <= beat + 4'd1;
      end
      if (!out_valid || !out_stall) out_valid <= busy;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) cur <= job;
    if (advance) begin
      out_byte <= byte_now;
      is_data  <= (beat >= BEAT_DATA0);
      last     <= (beat == BEAT_LAST);
    end
  end

endmodule

// ===== rtl/oled_text_glyph_writer.sv =====
// top level of the page-mode 6x8 oled text glyph writer
// Each input beat either places the cursor (no output) or draws a
// character, which produces nine output beats: page, column-high and
// column-low commands, then six glyph columns with last on the ninth. The
// registered output stage sends one byte per cycle while out_stall is low,
// so a stream of characters runs with no gap between them; a two-entry job
// queue lets the input side keep taking beats (including cursor placements)
// while earlier characters are still going out. The cursor advances by six
// columns after each character and wraps to column 0 of the next page,
// modulo PAGES, once it passes COLUMNS-8.
module oled_text_glyph_writer #(
  parameter int PAGES   = 8,
  parameter int COLUMNS = 128
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       kind,
  input  logic [6:0] column,
  input  logic [2:0] page,
  input  logic [7:0] char_code,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       is_data,
  output logic       last
);
  import otgw_pkg::*;

  glyph_job_t push_job, pop_job;
  logic       push, pop, queue_full, job_valid;

  otgw_front #(
    .PAGES   (PAGES),
    .COLUMNS (COLUMNS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .kind       (kind),
    .column     (column),
    .page       (page),
    .char_code  (char_code),
    .queue_full (queue_full),
    .push       (push),
    .push_job   (push_job)
  );

  otgw_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (push_job),
    .full      (queue_full),
    .pop       (pop),
    .job_valid (job_valid),
    .pop_job   (pop_job)
  );

  otgw_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job       (pop_job),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .is_data   (is_data),
    .last      (last)
  );

endmodule

// ===== rtl/otgw_checker.sv =====
// port-level checker for the glyph writer, bound to the top level
`include "oled_text_glyph_writer_macros.svh"

module otgw_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       kind,
  input logic [6:0] column,
  input logic [2:0] page,
  input logic [7:0] char_code,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic       is_data,
  input logic       last
);

  logic [18:0] in_word;
  logic [9:0]  out_word;
  logic        in_wait;
  logic        out_wait;
  logic        cmd_ok;

  assign in_word  = {kind, column, page, char_code};
  assign out_word = {out_byte, is_data, last};
  assign in_wait  = in_valid && in_stall;
  assign out_wait = out_valid && out_stall;
  assign cmd_ok   = (out_byte[7:3] == 5'h16) || (out_byte[7:3] == 5'h02) ||
                    (out_byte[7:4] == 4'h0);

  `OTGW_ASSERT_ALWAYS(a_reset_clears_out, rst |=> !out_valid, "out_valid after reset")
  `OTGW_ASSERT(a_out_hold, out_wait |=> out_valid && $stable(out_word), "stalled beat changed")
  `OTGW_ASSERT(a_in_hold, in_wait |=> in_valid && $stable(in_word), "stalled input beat changed")
  `OTGW_ASSERT(a_last_is_data, out_valid && last |-> is_data, "last on a command beat")
  `OTGW_ASSERT(a_cmd_code, out_valid && !is_data |-> cmd_ok, "bad command byte")

endmodule

bind oled_text_glyph_writer otgw_checker u_otgw_checker (.*);
